// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL of the antenna rotator controller.
// Clocked on clock, disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property check, reported through $error.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication checked on the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/dar_pkg.sv =====
// Types and constants for the antenna rotator controller.
// No dependencies; used by doppler_antenna_rotator_ctrl.
package dar_pkg;

   typedef enum logic [1:0] {
      REQ_TICK     = 2'd0,
      REQ_BYTE     = 2'd1,
      REQ_SAMPLE   = 2'd2,
      REQ_TX_READY = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      CSR_OP_ROTATE     = 3'd0,
      CSR_OP_STOP       = 3'd1,
      CSR_OP_RATE       = 3'd2,
      CSR_OP_STREAM_ON  = 3'd3,
      CSR_OP_STREAM_OFF = 3'd4
   } csr_index_type;

   localparam logic [7:0] OP_ROTATE_RST     = 8'd1;
   localparam logic [7:0] OP_STOP_RST       = 8'd2;
   localparam logic [7:0] OP_RATE_RST       = 8'd3;
   localparam logic [7:0] OP_STREAM_ON_RST  = 8'd4;
   localparam logic [7:0] OP_STREAM_OFF_RST = 8'd5;
   localparam logic [7:0] RATE_RST          = 8'd4;
   localparam logic [3:0] ANT_FIRST         = 4'b0001;
   localparam logic [3:0] ANT_WRAP          = 4'b1000;

   // Result word, packed from the top bit down; antenna_enables is in bits 3:0.
   typedef struct packed {
      logic       pad;
      logic       led_on;
      logic       conv_start;
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic [3:0] antenna_enables;
   } rsp_word_type;

endpackage

// ===== src/doppler_antenna_rotator_ctrl.sv =====
// Antenna rotator controller top level: event decode, rotation and streaming.
// Depends on dar_pkg and assert_macros.svh.
//
// Usage:
// - req channel: one event word per handshake. req_tuser is the event kind
//   (tick, received byte, sample done, transmitter ready); req_tdata carries
//   the byte and the sample.
// - rsp channel: exactly one result word per event, in order, with the
//   antenna enables after the event, the serial byte with its valid flag,
//   the conversion request and the sticky error LED.
// - csr port: opcode registers written by index while no event is in flight.
// Each result word is registered, in the result register or the skid register.
// Throughput: one event per cycle while req_tready is high; the whole update
// is one pass of logic between the state registers and the output registers.
// A two-entry output (result register plus skid register) keeps req_tready
// high while one result waits; req_tready drops only when both are full,
// i.e. after two words are stalled by rsp_tready low.
// Reset (synchronous): rotation and streaming off, element one selected,
// rate 4, phase and sample zero, LED off, opcodes back to 1..5.
`include "assert_macros.svh"

module doppler_antenna_rotator_ctrl (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // byte_in[7:0], sample_in[17:8], zero pad
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // antenna_enables[3:0], tx_valid[4],
                                    // tx_byte[12:5], conv_start[13], led_on[14]
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   logic [7:0] op_rotate_ff, op_stop_ff, op_rate_ff, op_stream_on_ff, op_stream_off_ff;

   logic       rotating_ff, rotating_in;
   logic       streaming_ff, streaming_in;
   logic [3:0] antenna_sel_ff, antenna_sel_in;
   logic [7:0] rate_ff, rate_in;
   logic [7:0] phase_ff, phase_in;
   logic [9:0] sample_ff, sample_in;
   logic       await_ff, await_in;
   logic       pending_ff, pending_in;
   logic       led_ff, led_in;

   logic                  out_valid_ff, out_valid_in;
   dar_pkg::rsp_word_type out_data_ff, out_data_in;
   logic                  skid_valid_ff, skid_valid_in;
   dar_pkg::rsp_word_type skid_data_ff, skid_data_in;

   dar_pkg::rsp_word_type result;
   dar_pkg::req_kind_type kind;
   logic [7:0]            byte_in;
   logic [9:0]            sample_req;
   logic [7:0]            phase_inc;
   logic [3:0]            ant_shift;
   logic                  accept;
   logic                  pop;

   assign kind       = dar_pkg::req_kind_type'(req_tuser);
   assign byte_in    = req_tdata[7:0];
   assign sample_req = req_tdata[17:8];
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign phase_inc  = phase_ff + 8'd1;
   assign ant_shift  = antenna_sel_ff >> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_rotate_ff     <= dar_pkg::OP_ROTATE_RST;
         op_stop_ff       <= dar_pkg::OP_STOP_RST;
         op_rate_ff       <= dar_pkg::OP_RATE_RST;
         op_stream_on_ff  <= dar_pkg::OP_STREAM_ON_RST;
         op_stream_off_ff <= dar_pkg::OP_STREAM_OFF_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            dar_pkg::CSR_OP_ROTATE:     op_rotate_ff     <= csr_wdata;
            dar_pkg::CSR_OP_STOP:       op_stop_ff       <= csr_wdata;
            dar_pkg::CSR_OP_RATE:       op_rate_ff       <= csr_wdata;
            dar_pkg::CSR_OP_STREAM_ON:  op_stream_on_ff  <= csr_wdata;
            dar_pkg::CSR_OP_STREAM_OFF: op_stream_off_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Event decode and state update.
   always_comb begin
      rotating_in    = rotating_ff;
      streaming_in   = streaming_ff;
      antenna_sel_in = antenna_sel_ff;
      rate_in        = rate_ff;
      phase_in       = phase_ff;
      sample_in      = sample_ff;
      await_in       = await_ff;
      pending_in     = pending_ff;
      led_in         = led_ff;
      result         = '0;
      unique case (kind)
         dar_pkg::REQ_TICK: begin
            if (streaming_ff) begin
               result.conv_start = 1'b1;
               result.tx_valid   = 1'b1;
               result.tx_byte    = sample_ff[7:0];
               pending_in        = 1'b1;
            end
            if (rotating_ff) begin
               if (phase_inc == rate_ff) begin
                  phase_in       = '0;
                  antenna_sel_in = (ant_shift == 4'd0) ? dar_pkg::ANT_WRAP : ant_shift;
               end else begin
                  phase_in = phase_inc;
               end
            end
         end
         dar_pkg::REQ_BYTE: begin
            if (await_ff) begin
               rate_in  = byte_in;
               await_in = 1'b0;
            end else if (byte_in == op_rotate_ff) begin
               rotating_in = 1'b1;
            end else if (byte_in == op_stop_ff) begin
               rotating_in = 1'b0;
            end else if (byte_in == op_rate_ff) begin
               await_in = 1'b1;
            end else if (byte_in == op_stream_on_ff) begin
               streaming_in = 1'b1;
            end else if (byte_in == op_stream_off_ff) begin
               streaming_in = 1'b0;
            end else begin
               led_in = 1'b1;
            end
         end
         dar_pkg::REQ_SAMPLE: begin
            sample_in = sample_req;
         end
         dar_pkg::REQ_TX_READY: begin
            if (pending_ff) begin
               result.tx_valid = 1'b1;
               result.tx_byte  = {antenna_sel_ff, 2'b00, sample_ff[9:8]};
               pending_in      = 1'b0;
            end
         end
         default: ;
      endcase
      result.antenna_enables = antenna_sel_in;
      result.led_on          = led_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rotating_ff    <= 1'b0;
         streaming_ff   <= 1'b0;
         antenna_sel_ff <= dar_pkg::ANT_FIRST;
         rate_ff        <= dar_pkg::RATE_RST;
         phase_ff       <= '0;
         sample_ff      <= '0;
         await_ff       <= 1'b0;
         pending_ff     <= 1'b0;
         led_ff         <= 1'b0;
      end else if (accept) begin
         rotating_ff    <= rotating_in;
         streaming_ff   <= streaming_in;
         antenna_sel_ff <= antenna_sel_in;
         rate_ff        <= rate_in;
         phase_ff       <= phase_in;
         sample_ff      <= sample_in;
         await_ff       <= await_in;
         pending_ff     <= pending_in;
         led_ff         <= led_in;
      end
   end

   // Result register with one skid entry behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_data_in  = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   `ASSERT_CLK(a_ant_onehot, $onehot(antenna_sel_ff), "antenna select lost one-hot")
   `ASSERT_CLK(a_skid_order, !skid_valid_ff || out_valid_ff, "skid word without result word")
   `ASSERT_NEXT(a_led_sticky, led_ff, led_ff, "error LED cleared without reset")
   `ASSERT_NEXT(a_idle_state, !accept && !csr_we, $stable(phase_ff) && $stable(rate_ff),
                "rotation state changed without an event")

endmodule

// ===== tb/dar_stream_checker.sv =====
// Checker for doppler_antenna_rotator_ctrl: watches the event, result and csr ports,
// predicts each result word and compares it field by field, oldest first.
// Depends on dar_pkg.
module dar_stream_checker
   import dar_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // byte_in[7:0], sample_in[17:8], zero pad
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // antenna_enables[3:0], tx_valid[4],
                                    // tx_byte[12:5], conv_start[13], led_on[14]
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [7:0]  csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          checked
);

   logic [7:0]   op_code [5];
   logic         rotating, streaming, want_operand, high_pending, led;
   logic [3:0]   ant;
   logic [7:0]   rate, phase;
   logic [9:0]   sample_hold;
   rsp_word_type expected_words [$];
   rsp_word_type got, want, next_word;

   initial begin
      fail_count = 0;
      pending = 0;
      checked = 0;
   end

   task automatic report_mismatch(input string what, input int got_v, input int want_v);
      fail_count++;
      $display("mismatch: %s got %0h expected %0h after %0d words", what, got_v, want_v,
               checked);
   endtask

   task automatic step_rotator(input req_kind_type kind, input logic [7:0] b,
                               input logic [9:0] s, output rsp_word_type w);
      w = '0;
      case (kind)
         REQ_TICK: begin
            if (streaming) begin
               w.conv_start = 1'b1;
               w.tx_valid = 1'b1;
               w.tx_byte = sample_hold[7:0];
               high_pending = 1'b1;
            end
            if (rotating) begin
               phase = phase + 8'd1;
               if (phase == rate) begin
                  phase = '0;
                  ant = ant >> 1;
                  if (ant == '0)
                     ant = ANT_WRAP;
               end
            end
         end
         REQ_BYTE: begin
            if (want_operand) begin
               rate = b;
               want_operand = 1'b0;
            end else if (b == op_code[CSR_OP_ROTATE])
               rotating = 1'b1;
            else if (b == op_code[CSR_OP_STOP])
               rotating = 1'b0;
            else if (b == op_code[CSR_OP_RATE])
               want_operand = 1'b1;
            else if (b == op_code[CSR_OP_STREAM_ON])
               streaming = 1'b1;
            else if (b == op_code[CSR_OP_STREAM_OFF])
               streaming = 1'b0;
            else
               led = 1'b1;
         end
         REQ_SAMPLE: sample_hold = s;
         default: begin
            if (high_pending) begin
               w.tx_valid = 1'b1;
               w.tx_byte = {ant, 2'b00, sample_hold[9:8]};
               high_pending = 1'b0;
            end
         end
      endcase
      w.antenna_enables = ant;
      w.led_on = led;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         op_code[CSR_OP_ROTATE] = OP_ROTATE_RST;
         op_code[CSR_OP_STOP] = OP_STOP_RST;
         op_code[CSR_OP_RATE] = OP_RATE_RST;
         op_code[CSR_OP_STREAM_ON] = OP_STREAM_ON_RST;
         op_code[CSR_OP_STREAM_OFF] = OP_STREAM_OFF_RST;
         rotating = 1'b0;
         streaming = 1'b0;
         want_operand = 1'b0;
         high_pending = 1'b0;
         led = 1'b0;
         ant = ANT_FIRST;
         rate = RATE_RST;
         phase = '0;
         sample_hold = '0;
         expected_words.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_words.size() == 0)
               report_mismatch("word with nothing expected", rsp_tdata, 0);
            else begin
               want = expected_words.pop_front();
               checked++;
               if (got.antenna_enables !== want.antenna_enables)
                  report_mismatch("antenna_enables", got.antenna_enables,
                                  want.antenna_enables);
               if (got.tx_valid !== want.tx_valid)
                  report_mismatch("tx_valid", got.tx_valid, want.tx_valid);
               if (got.tx_byte !== want.tx_byte)
                  report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
               if (got.conv_start !== want.conv_start)
                  report_mismatch("conv_start", got.conv_start, want.conv_start);
               if (got.led_on !== want.led_on)
                  report_mismatch("led_on", got.led_on, want.led_on);
            end
         end
         if (csr_we && csr_addr <= CSR_OP_STREAM_OFF)
            op_code[csr_addr] = csr_wdata;
         if (req_tvalid && req_tready) begin
            step_rotator(req_kind_type'(req_tuser), req_tdata[7:0], req_tdata[17:8],
                         next_word);
            expected_words.push_back(next_word);
         end
      end
      pending = expected_words.size();
   end

endmodule

// ===== tb/tb_doppler_antenna_rotator_ctrl.sv =====
// Testbench top for doppler_antenna_rotator_ctrl: drives event words and opcode
// settings, random idling and a long result hold; gives the verdict.
// Depends on dar_pkg, the RTL and dar_stream_checker.
module tb_doppler_antenna_rotator_ctrl;
   import dar_pkg::*;

   localparam int LIMIT = 150000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [7:0]  csr_wdata = '0;

   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_off = 0;
   int          sent = 0;
   int          cycles = 0;
   int          fails, pending, checked;
   logic [7:0]  op_code [5];

   doppler_antenna_rotator_ctrl DUT (.*);

   dar_stream_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .fail_count(fails), .pending(pending), .checked(checked)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_doppler_antenna_rotator_ctrl: errors");
         $finish;
      end
   end

   task automatic send_word(input req_kind_type kind, input logic [7:0] b,
                            input logic [9:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {6'b0, s, b};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_word(REQ_BYTE, b, 10'($urandom));
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_word(REQ_TICK, 8'($urandom), 10'($urandom));
   endtask

   // drain all expected words, then idle for margin
   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0)
         @(negedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_opcodes(input logic [7:0] v [5]);
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1'b1;
         csr_addr <= 3'(csr_index_type'(i));
         csr_wdata <= v[i];
         op_code[i] = v[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic send_random();
      int pick;
      int c;
      pick = $urandom_range(99);
      if (pick < 36)
         send_word(REQ_TICK, 8'($urandom), 10'($urandom));
      else if (pick < 50)
         send_word(REQ_SAMPLE, 8'($urandom), 10'($urandom));
      else if (pick < 68)
         send_word(REQ_TX_READY, 8'($urandom), 10'($urandom));
      else if (pick < 74)
         send_byte(8'($urandom));
      else begin
         c = $urandom_range(99);
         if (c < 30)
            send_byte(op_code[CSR_OP_ROTATE]);
         else if (c < 40)
            send_byte(op_code[CSR_OP_STOP]);
         else if (c < 60) begin
            send_byte(op_code[CSR_OP_RATE]);
            send_byte(($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(9)));
         end else if (c < 88)
            send_byte(op_code[CSR_OP_STREAM_ON]);
         else
            send_byte(op_code[CSR_OP_STREAM_OFF]);
      end
   endtask

   task automatic run_random(input int n);
      int stop_at;
      stop_at = sent + n;
      while (sent < stop_at)
         send_random();
   endtask

   initial begin
      logic [7:0] ops [5];
      bit         dup;
      op_code = '{OP_ROTATE_RST, OP_STOP_RST, OP_RATE_RST, OP_STREAM_ON_RST,
                  OP_STREAM_OFF_RST};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset opcodes, no idling
      send_word(REQ_TX_READY, 8'hFF, 10'h3FF);
      send_word(REQ_TICK, 8'h00, 10'h000);
      send_word(REQ_SAMPLE, 8'h00, 10'h3FF);
      send_byte(op_code[CSR_OP_STREAM_ON]);
      send_ticks(2);
      send_word(REQ_TX_READY, 8'h00, 10'h000);
      send_word(REQ_TX_READY, 8'h00, 10'h000);
      send_byte(op_code[CSR_OP_ROTATE]);
      send_byte(op_code[CSR_OP_RATE]);
      send_byte(8'd1);
      send_ticks(4);
      send_word(REQ_SAMPLE, 8'hFF, 10'h000);
      send_byte(op_code[CSR_OP_STREAM_OFF]);
      send_word(REQ_TX_READY, 8'h00, 10'h000);
      send_byte(op_code[CSR_OP_RATE]);
      send_byte(8'hFF);
      send_byte(op_code[CSR_OP_STOP]);
      send_ticks(1);
      send_byte(8'h00);
      send_byte(8'hFF);

      // rate zero: a step every 256 ticks; then a phase left above a smaller rate
      send_byte(op_code[CSR_OP_ROTATE]);
      send_byte(op_code[CSR_OP_RATE]);
      send_byte(8'd0);
      send_ticks(260);
      send_byte(op_code[CSR_OP_RATE]);
      send_byte(8'd200);
      send_ticks(5);
      send_byte(op_code[CSR_OP_RATE]);
      send_byte(8'd2);
      send_ticks(260);
      settle();

      // extreme opcode values, sender idling
      set_opcodes('{8'd0, 8'd255, 8'd128, 8'd127, 8'd1});
      send_idle_pct = 46;
      run_random(150);
      settle();

      // all opcodes equal: rotate wins every compare; receiver stalling
      set_opcodes('{8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA});
      send_idle_pct = 0;
      recv_stall_pct = 46;
      run_random(100);
      settle();

      // random distinct opcodes, both sides idling
      for (int i = 0; i < 5; i++) begin
         do begin
            ops[i] = 8'($urandom);
            dup = 1'b0;
            for (int j = 0; j < i; j++)
               if (ops[j] == ops[i])
                  dup = 1'b1;
         end while (dup);
      end
      set_opcodes(ops);
      send_idle_pct = 29;
      recv_stall_pct = 29;
      run_random(150);
      settle();

      // reset opcodes again, long result hold while words keep coming
      set_opcodes('{OP_ROTATE_RST, OP_STOP_RST, OP_RATE_RST, OP_STREAM_ON_RST,
                    OP_STREAM_OFF_RST});
      send_idle_pct = 0;
      recv_stall_pct = 0;
      if (hold_off == 0)
         hold_off = 400;
      run_random(150);
      recv_stall_pct = 10;
      run_random(100);
      settle();
      repeat (5) @(posedge clock);

      $display("covered %0d event words over five opcode settings and four idling mixes,",
               sent);
      $display("including rate-zero rotation and a 400-cycle result hold; %0d words checked",
               checked);
      if (fails == 0)
         $display("tb_doppler_antenna_rotator_ctrl: clean");
      else
         $display("tb_doppler_antenna_rotator_ctrl: errors");
      $finish;
   end

endmodule

// ===== doppler_antenna_rotator_ctrl.f =====
+incdir+src
src/dar_pkg.sv
src/doppler_antenna_rotator_ctrl.sv
tb/dar_stream_checker.sv
tb/tb_doppler_antenna_rotator_ctrl.sv
